FILE: sv/dsgm_pkg.sv
// Shared types, constants and helpers for the dual-source gamepad merge block.
`timescale 1ns / 1ps
package dsgm_pkg;

	localparam int PORT_COUNT = 4;
	localparam int PIDX_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int PORT_CMP_W = 5;

	localparam logic [2:0] OP_SET_TOUCH = 3'd0;
	localparam logic [2:0] OP_SET_CTRL  = 3'd1;
	localparam logic [2:0] OP_CLR_PORT  = 3'd2;
	localparam logic [2:0] OP_CLR_TOUCH = 3'd3;
	localparam logic [2:0] OP_CLR_CTRL  = 3'd4;
	localparam logic [2:0] OP_READ      = 3'd5;
	localparam logic [2:0] OP_CONSUME   = 3'd6;

	localparam logic SRC_TOUCH = 1'b0;
	localparam logic SRC_CTRL  = 1'b1;

	typedef enum logic [2:0] {
		K_SET,
		K_CLR_PORT,
		K_CLR_SRC,
		K_READ,
		K_CONSUME,
		K_READ_ZERO
	} kind_t;

	// one source of one port
	typedef struct packed {
		logic             online;
		logic [15:0]      button;
		logic [15:0]      latch;
		logic [3:0][7:0]  stick;
		logic [3:0][7:0]  level;
	} src_t;

	typedef struct packed {
		kind_t            kind;
		logic [1:0]       port;
		logic             src;
		logic             online;
		logic [15:0]      button;
		logic [3:0][7:0]  stick;
		logic [3:0][7:0]  level;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	typedef struct packed {
		logic             connected;
		logic [15:0]      button;
		logic [3:0][7:0]  stick;
		logic [3:0][7:0]  level;
	} res_t;

	// magnitude of a two's complement byte; -128 gives 8'h80 = 128
	function automatic logic [7:0] mag8(input logic [7:0] v);
		return v[7] ? (8'd0 - v) : v;
	endfunction

endpackage

FILE: sv/dsgm_front.sv
// Front end: decodes incoming operations and queues commands for the back end.
`timescale 1ns / 1ps
module dsgm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          operation,
	input  logic [1:0]          port,
	input  logic                source_connected,
	input  logic [15:0]         button,
	input  logic [3:0][7:0]     stick,
	input  logic [3:0][7:0]     level,
	output dsgm_pkg::cmd_req_t  req,
	input  logic                take
);
	import dsgm_pkg::*;

	cmd_t       cmd;
	logic       keep;
	logic       port_ok;
	cmd_t       q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign port_ok = PORT_CMP_W'(port) < PORT_CMP_W'(PORT_COUNT);

	always_comb begin
		cmd.kind   = K_READ_ZERO;
		cmd.port   = port;
		cmd.src    = SRC_TOUCH;
		cmd.online = source_connected;
		cmd.button = button;
		cmd.stick  = stick;
		cmd.level  = level;
		keep       = 1'b0;
		case (operation)
			OP_SET_TOUCH, OP_SET_CTRL: begin
				cmd.kind = K_SET;
				cmd.src  = (operation == OP_SET_CTRL) ? SRC_CTRL : SRC_TOUCH;
				keep     = port_ok;
			end
			OP_CLR_PORT: begin
				cmd.kind = K_CLR_PORT;
				keep     = port_ok;
			end
			OP_CLR_TOUCH, OP_CLR_CTRL: begin
				cmd.kind = K_CLR_SRC;
				cmd.src  = (operation == OP_CLR_CTRL) ? SRC_CTRL : SRC_TOUCH;
				keep     = port_ok;
			end
			OP_READ: begin
				cmd.kind = port_ok ? K_READ : K_READ_ZERO;
				keep     = 1'b1;
			end
			OP_CONSUME: begin
				cmd.kind = port_ok ? K_CONSUME : K_READ_ZERO;
				keep     = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	// ops with no effect and no result are dropped on transfer
	assign full  = (cnt_q == 2'd2);
	assign wr_en = push && !full && keep;
	assign rd_en = take && (cnt_q != 2'd0);

	assign req.valid = (cnt_q != 2'd0);
	assign req.cmd   = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= ~wr_q;
			end
			if (rd_en) begin
				rd_q <= ~rd_q;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/dsgm_back.sv
// Back end: per-port source state, command execution, merge and result queue.
`timescale 1ns / 1ps
module dsgm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dsgm_pkg::cmd_req_t  req,
	output logic                take,
	output logic                empty,
	input  logic                pop,
	output dsgm_pkg::res_t      result
);
	import dsgm_pkg::*;

	src_t              st_q [PORT_COUNT][2];
	res_t              res_q [2];
	logic              rwr_q;
	logic              rrd_q;
	logic [1:0]        rcnt_q;
	logic [PIDX_W-1:0] idx;
	src_t              t_src;
	src_t              c_src;
	src_t              set_src;
	res_t              merged;
	logic [3:0][7:0]   ts;
	logic [3:0][7:0]   cs;
	logic [3:0][7:0]   tl;
	logic [3:0][7:0]   cl;
	logic              produce;
	logic              room;
	logic              res_wr;
	logic              res_rd;

	assign idx   = PIDX_W'(req.cmd.port);
	assign t_src = st_q[idx][SRC_TOUCH];
	assign c_src = st_q[idx][SRC_CTRL];

	always_comb begin
		ts = t_src.online ? t_src.stick : '0;
		tl = t_src.online ? t_src.level : '0;
		cs = c_src.online ? c_src.stick : '0;
		cl = c_src.online ? c_src.level : '0;
		merged.connected = 1'b1;
		merged.button = (t_src.online ? t_src.button : 16'd0)
			| (c_src.online ? c_src.button : 16'd0)
			| t_src.latch | c_src.latch;
		for (int l = 0; l < 4; l++) begin
			// tie goes to touch
			merged.stick[l] = (mag8(cs[l]) > mag8(ts[l])) ? cs[l] : ts[l];
			merged.level[l] = (tl[l] > cl[l]) ? tl[l] : cl[l];
		end
		if (!(t_src.online || c_src.online) || req.cmd.kind == K_READ_ZERO) begin
			merged = '0;
		end
	end

	always_comb begin
		set_src        = st_q[idx][req.cmd.src];
		set_src.latch  = set_src.latch | (req.cmd.button & ~set_src.button);
		set_src.button = req.cmd.button;
		set_src.online = req.cmd.online;
		set_src.stick  = req.cmd.stick;
		set_src.level  = req.cmd.level;
	end

	assign produce = req.cmd.kind inside {K_READ, K_CONSUME, K_READ_ZERO};
	assign room    = (rcnt_q != 2'd2) || pop;
	assign take    = req.valid && room;
	assign res_wr  = take && produce;
	assign res_rd  = pop && (rcnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORT_COUNT; p++) begin
				st_q[p][0] <= '0;
				st_q[p][1] <= '0;
			end
		end else if (take) begin
			case (req.cmd.kind)
				K_SET: st_q[idx][req.cmd.src] <= set_src;
				K_CLR_PORT: begin
					st_q[idx][SRC_TOUCH] <= '0;
					st_q[idx][SRC_CTRL]  <= '0;
				end
				K_CLR_SRC: st_q[idx][req.cmd.src] <= '0;
				K_CONSUME: begin
					st_q[idx][SRC_TOUCH].latch <= 16'd0;
					st_q[idx][SRC_CTRL].latch  <= 16'd0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q[rwr_q] <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= 1'b0;
			rrd_q  <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			if (res_wr) begin
				rwr_q <= ~rwr_q;
			end
			if (res_rd) begin
				rrd_q <= ~rrd_q;
			end
			case ({res_wr, res_rd})
				2'b10:   rcnt_q <= rcnt_q + 2'd1;
				2'b01:   rcnt_q <= rcnt_q - 2'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

	assign empty  = (rcnt_q == 2'd0);
	assign result = res_q[rrd_q];

endmodule

FILE: sv/dual_source_gamepad_merge.sv
// Top level of the dual-source gamepad merge: front decoder, command queue, back end.
// A read or consume command waits in the command queue; its result enters the result
// queue when the back end takes the command.
// Throughput: one item per cycle while the result queue has room or is being popped.
// Command queue and result queue are 2 deep each; full rises only when both slots hold.
// Reset (arst_n low, asynchronous): all sources disconnected, values and latches zero,
// both queues empty. No clearing pass is needed.
`timescale 1ns / 1ps
module dual_source_gamepad_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        operation,
	input  logic [1:0]        port,
	input  logic              source_connected,
	input  logic [15:0]       button,
	input  logic signed [7:0] stick_x,
	input  logic signed [7:0] stick_y,
	input  logic signed [7:0] cstick_x,
	input  logic signed [7:0] cstick_y,
	input  logic [7:0]        trig_l,
	input  logic [7:0]        trig_r,
	input  logic [7:0]        press_a,
	input  logic [7:0]        press_b,
	output logic              empty,
	input  logic              pop,
	output logic              merged_connected,
	output logic [15:0]       merged_button,
	output logic signed [7:0] merged_stick_x,
	output logic signed [7:0] merged_stick_y,
	output logic signed [7:0] merged_cstick_x,
	output logic signed [7:0] merged_cstick_y,
	output logic [7:0]        merged_trig_l,
	output logic [7:0]        merged_trig_r,
	output logic [7:0]        merged_press_a,
	output logic [7:0]        merged_press_b
);
	import dsgm_pkg::*;

	cmd_req_t        req;
	logic            take;
	res_t            result;
	logic [3:0][7:0] stick;
	logic [3:0][7:0] level;

	assign stick = {cstick_y, cstick_x, stick_y, stick_x};
	assign level = {press_b, press_a, trig_r, trig_l};

	dsgm_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.operation        (operation),
		.port             (port),
		.source_connected (source_connected),
		.button           (button),
		.stick            (stick),
		.level            (level),
		.req              (req),
		.take             (take)
	);

	dsgm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	assign merged_connected = result.connected;
	assign merged_button    = result.button;
	assign merged_stick_x   = result.stick[0];
	assign merged_stick_y   = result.stick[1];
	assign merged_cstick_x  = result.stick[2];
	assign merged_cstick_y  = result.stick[3];
	assign merged_trig_l    = result.level[0];
	assign merged_trig_r    = result.level[1];
	assign merged_press_a   = result.level[2];
	assign merged_press_b   = result.level[3];

endmodule

FILE: sv/dsgm_checker.sv
// Port-level checker for the dual-source gamepad merge, bound to the top level.
`timescale 1ns / 1ps
module dsgm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input logic              merged_connected,
	input logic [15:0]       merged_button,
	input logic signed [7:0] merged_stick_x,
	input logic signed [7:0] merged_stick_y,
	input logic signed [7:0] merged_cstick_x,
	input logic signed [7:0] merged_cstick_y,
	input logic [7:0]        merged_trig_l,
	input logic [7:0]        merged_trig_r,
	input logic [7:0]        merged_press_a,
	input logic [7:0]        merged_press_b
);

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(merged_button) && $stable(merged_connected)
			&& $stable(merged_stick_x) && $stable(merged_trig_l)))
		else $error("waiting result changed or vanished");

	// a disconnected result carries only zeros
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !merged_connected) |-> (merged_button == 16'd0
			&& merged_stick_x == 8'sd0 && merged_stick_y == 8'sd0
			&& merged_cstick_x == 8'sd0 && merged_cstick_y == 8'sd0
			&& merged_trig_l == 8'd0 && merged_trig_r == 8'd0
			&& merged_press_a == 8'd0 && merged_press_b == 8'd0))
		else $error("disconnected result has nonzero fields");

	// the input queue fills only through a push
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind dual_source_gamepad_merge dsgm_checker u_dsgm_checker (.*);

FILE: tb/sv/dual_source_gamepad_merge_test.sv
// Self-checking testbench for dual_source_gamepad_merge: directed table, then random phases.
`timescale 1ns / 1ps
module dual_source_gamepad_merge_test;
	import dsgm_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int ENTRY_COUNT = PORT_COUNT * 2;
	localparam int HOLD_CYCLES = 400;
	localparam int SHOWN_ERRORS = 40;

	typedef struct packed {
		logic [2:0]      op;
		logic [1:0]      port;
		logic            conn;
		logic [15:0]     btn;
		logic [3:0][7:0] stick;
		logic [3:0][7:0] level;
	} pad_cmd_t;

	typedef struct {
		pad_cmd_t cmd;
		bit       expect_zero;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [2:0]        operation = '0;
	logic [1:0]        port = '0;
	logic              source_connected = 1'b0;
	logic [15:0]       button = '0;
	logic signed [7:0] stick_x = '0;
	logic signed [7:0] stick_y = '0;
	logic signed [7:0] cstick_x = '0;
	logic signed [7:0] cstick_y = '0;
	logic [7:0]        trig_l = '0;
	logic [7:0]        trig_r = '0;
	logic [7:0]        press_a = '0;
	logic [7:0]        press_b = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic              merged_connected;
	logic [15:0]       merged_button;
	logic signed [7:0] merged_stick_x;
	logic signed [7:0] merged_stick_y;
	logic signed [7:0] merged_cstick_x;
	logic signed [7:0] merged_cstick_y;
	logic [7:0]        merged_trig_l;
	logic [7:0]        merged_trig_r;
	logic [7:0]        merged_press_a;
	logic [7:0]        merged_press_b;

	src_t     pad_state [ENTRY_COUNT];
	res_t     merged_expected [$];
	dir_row_t directed_rows [$];
	int       error_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	bit       recv_hold_req = 1'b0;

	dual_source_gamepad_merge DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.port(port),
		.source_connected(source_connected),
		.button(button),
		.stick_x(stick_x),
		.stick_y(stick_y),
		.cstick_x(cstick_x),
		.cstick_y(cstick_y),
		.trig_l(trig_l),
		.trig_r(trig_r),
		.press_a(press_a),
		.press_b(press_b),
		.empty(empty),
		.pop(pop),
		.merged_connected(merged_connected),
		.merged_button(merged_button),
		.merged_stick_x(merged_stick_x),
		.merged_stick_y(merged_stick_y),
		.merged_cstick_x(merged_cstick_x),
		.merged_cstick_y(merged_cstick_y),
		.merged_trig_l(merged_trig_l),
		.merged_trig_r(merged_trig_r),
		.merged_press_a(merged_press_a),
		.merged_press_b(merged_press_b)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Updates the pad state for one op; returns 1 with the merged view for read/consume.
	function automatic bit apply_pad_op(input pad_cmd_t c, output res_t r);
		src_t t, k;
		int   base, e, a, b, ma, mb, lane;
		bit   in_range;
		r = '0;
		in_range = int'(c.port) < PORT_COUNT;
		base = int'(c.port) * 2;
		case (c.op)
			OP_SET_TOUCH, OP_SET_CTRL: begin
				if (in_range) begin
					e = base + ((c.op == OP_SET_CTRL) ? 1 : 0);
					// rising buttons since the last stored status
					pad_state[e].latch  = pad_state[e].latch | (c.btn & ~pad_state[e].button);
					pad_state[e].button = c.btn;
					pad_state[e].online = c.conn;
					pad_state[e].stick  = c.stick;
					pad_state[e].level  = c.level;
				end
				return 1'b0;
			end
			OP_CLR_PORT: begin
				if (in_range) begin
					pad_state[base] = '0;
					pad_state[base + 1] = '0;
				end
				return 1'b0;
			end
			OP_CLR_TOUCH: begin
				if (in_range)
					pad_state[base] = '0;
				return 1'b0;
			end
			OP_CLR_CTRL: begin
				if (in_range)
					pad_state[base + 1] = '0;
				return 1'b0;
			end
			OP_READ, OP_CONSUME: begin
				if (in_range) begin
					t = pad_state[base];
					k = pad_state[base + 1];
					if (t.online || k.online) begin
						// an offline source merges as zeros, but its latch still counts
						if (!t.online) begin
							t.button = '0;
							t.stick = '0;
							t.level = '0;
						end
						if (!k.online) begin
							k.button = '0;
							k.stick = '0;
							k.level = '0;
						end
						r.connected = 1'b1;
						r.button = t.button | k.button | t.latch | k.latch;
						for (lane = 0; lane < 4; lane++) begin
							a = $signed(t.stick[lane]);
							b = $signed(k.stick[lane]);
							ma = (a < 0) ? -a : a;
							mb = (b < 0) ? -b : b;
							r.stick[lane] = (mb > ma) ? k.stick[lane] : t.stick[lane];
							r.level[lane] = (k.level[lane] > t.level[lane]) ?
								k.level[lane] : t.level[lane];
						end
					end
					if (c.op == OP_CONSUME) begin
						pad_state[base].latch = '0;
						pad_state[base + 1].latch = '0;
					end
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_row(input bit expect_zero, input logic [2:0] op,
			input logic [1:0] p, input logic conn, input logic [15:0] btn,
			input logic [7:0] sx, input logic [7:0] sy, input logic [7:0] ux,
			input logic [7:0] uy, input logic [7:0] tl, input logic [7:0] tr,
			input logic [7:0] aa, input logic [7:0] ab);
		dir_row_t row;
		row.cmd.op = op;
		row.cmd.port = p;
		row.cmd.conn = conn;
		row.cmd.btn = btn;
		row.cmd.stick = {uy, ux, sy, sx};
		row.cmd.level = {ab, aa, tr, tl};
		row.expect_zero = expect_zero;
		directed_rows.push_back(row);
	endfunction

	// axis values biased toward extremes and equal-magnitude pairs
	function automatic logic [7:0] pick_axis();
		case ($urandom_range(9))
			0: return 8'h80;
			1: return 8'h7F;
			2: return 8'h81;
			3: return 8'h00;
			4: return 8'h05;
			5: return 8'hFB;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pad_cmd_t random_pad_op(input bit read_heavy);
		pad_cmd_t c;
		int       roll, lane;
		roll = $urandom_range(99);
		if (read_heavy)
			c.op = (roll < 10) ? OP_SET_TOUCH : (roll < 20) ? OP_SET_CTRL :
				(roll < 60) ? OP_READ : OP_CONSUME;
		else
			c.op = (roll < 22) ? OP_SET_TOUCH : (roll < 44) ? OP_SET_CTRL :
				(roll < 49) ? OP_CLR_PORT : (roll < 54) ? OP_CLR_TOUCH :
				(roll < 59) ? OP_CLR_CTRL : (roll < 80) ? OP_READ :
				(roll < 97) ? OP_CONSUME : OP_UNUSED;
		c.port = 2'($urandom_range(3));
		c.conn = ($urandom_range(9) != 0);
		case ($urandom_range(3))
			0: c.btn = 16'($urandom);
			1: c.btn = 16'($urandom & $urandom);
			2: c.btn = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
			default: c.btn = 16'($urandom & $urandom & $urandom);
		endcase
		for (lane = 0; lane < 4; lane++) begin
			c.stick[lane] = pick_axis();
			c.level[lane] = pick_level();
		end
		return c;
	endfunction

	// Offers one op, waits for its transfer, then records what should come back.
	task automatic offer_pad_op(input pad_cmd_t c, input bit expect_zero);
		res_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		operation <= c.op;
		port <= c.port;
		source_connected <= c.conn;
		button <= c.btn;
		stick_x <= c.stick[0];
		stick_y <= c.stick[1];
		cstick_x <= c.stick[2];
		cstick_y <= c.stick[3];
		trig_l <= c.level[0];
		trig_r <= c.level[1];
		press_a <= c.level[2];
		press_b <= c.level[3];
		do @(posedge clk); while (full);
		if (apply_pad_op(c, r))
			merged_expected.push_back(expect_zero ? res_t'('0) : r);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= SHOWN_ERRORS)
				$display("%0t %s expected %h got %h", $time, name, want, got);
		end
	endtask

	// result side: check each transfer, then choose pop for the next edge
	initial begin
		res_t w;
		int   hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (merged_expected.size() == 0) begin
					error_count++;
					if (error_count <= SHOWN_ERRORS)
						$display("%0t unexpected result, none pending", $time);
				end else begin
					w = merged_expected.pop_front();
					check_field("merged_connected", {15'b0, w.connected},
						{15'b0, merged_connected});
					check_field("merged_button", w.button, merged_button);
					check_field("merged_stick_x", {8'h00, w.stick[0]},
						{8'h00, merged_stick_x});
					check_field("merged_stick_y", {8'h00, w.stick[1]},
						{8'h00, merged_stick_y});
					check_field("merged_cstick_x", {8'h00, w.stick[2]},
						{8'h00, merged_cstick_x});
					check_field("merged_cstick_y", {8'h00, w.stick[3]},
						{8'h00, merged_cstick_y});
					check_field("merged_trig_l", {8'h00, w.level[0]},
						{8'h00, merged_trig_l});
					check_field("merged_trig_r", {8'h00, w.level[1]},
						{8'h00, merged_trig_r});
					check_field("merged_press_a", {8'h00, w.level[2]},
						{8'h00, merged_press_a});
					check_field("merged_press_b", {8'h00, w.level[3]},
						{8'h00, merged_press_b});
				end
			end
			if (recv_hold_req) begin
				recv_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int ph, n, count;
		bit read_heavy;
		for (n = 0; n < ENTRY_COUNT; n++)
			pad_state[n] = '0;

		add_row(1, OP_READ,      0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, OP_CONSUME,   3, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_SET_TOUCH, 0, 1, 16'hFFFF, 8'h7F, 8'h80, 8'hFF, 8'h01,
			8'hFF, 8'h00, 8'h80, 8'h7F);
		add_row(0, OP_SET_CTRL,  0, 1, 16'h0000, 8'h80, 8'h7F, 8'h01, 8'hFF,
			8'h00, 8'hFF, 8'h7F, 8'h80);
		add_row(0, OP_READ,      0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_CONSUME,   0, 1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_row(0, OP_READ,      0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		// offline source: values stored and latch updated, merge ignores it
		add_row(0, OP_SET_TOUCH, 0, 0, 16'h00F0, 8'h10, 8'h20, 8'h30, 8'h40,
			8'h11, 8'h22, 8'h33, 8'h44);
		add_row(0, OP_READ,      0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_SET_CTRL,  1, 0, 16'h1234, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// neither source connected: all zero even with latches set
		add_row(1, OP_READ,      1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, OP_CONSUME,   1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_SET_CTRL,  1, 1, 16'h1234, 8'h81, 8'h01, 8'h00, 8'hFF,
			8'h01, 8'h02, 8'hFE, 8'hFF);
		add_row(0, OP_READ,      1, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_CLR_TOUCH, 0, 1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_row(0, OP_READ,      0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_CLR_CTRL,  0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, OP_READ,      0, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_SET_TOUCH, 2, 1, 16'hA5A5, 8'h80, 8'h80, 8'h80, 8'h80,
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_row(0, OP_CLR_PORT,  2, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(1, OP_READ,      2, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);
		add_row(0, OP_UNUSED,    3, 1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// equal magnitudes on opposite signs: touch wins the tie
		add_row(0, OP_SET_TOUCH, 3, 1, 16'h5A5A, 8'h05, 8'hFB, 8'h00, 8'h80,
			8'h01, 8'h02, 8'h03, 8'h04);
		add_row(0, OP_SET_CTRL,  3, 1, 16'hA5A5, 8'hFB, 8'h05, 8'h80, 8'h81,
			8'h04, 8'h03, 8'h02, 8'h01);
		add_row(0, OP_CONSUME,   3, 0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_pad_op(directed_rows[i].cmd, directed_rows[i].expect_zero);

		for (ph = 0; ph < 5; ph++) begin
			read_heavy = 1'b0;
			count = 350;
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					count = 400;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				3: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
				default: begin
					// receiver holds off while reads keep coming, so full must rise
					send_idle_pct = 0;
					recv_stall_pct = 0;
					recv_hold_req = 1'b1;
					read_heavy = 1'b1;
				end
			endcase
			for (n = 0; n < count; n++)
				offer_pad_op(random_pad_op(read_heavy), 1'b0);
		end

		push <= 1'b0;
		recv_stall_pct = 0;
		while (merged_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
